>>> rtl/pasv_pkg.sv
// pasv_pkg: character codes, match stages and result word layout for the
// passive-reply port parser. No dependencies.
`default_nettype none

package pasv_pkg;

	// Character codes
	localparam logic [7:0] CHR_OPEN  = 8'h28; // '('
	localparam logic [7:0] CHR_CLOSE = 8'h29; // ')'
	localparam logic [7:0] CHR_COMMA = 8'h2C; // ','
	localparam logic [7:0] CHR_ZERO  = 8'h30; // '0'
	localparam logic [7:0] CHR_NINE  = 8'h39; // '9'

	// Match stages: searching, then reading numbers one to six
	localparam int unsigned STAGE_W = 3;
	localparam logic [STAGE_W-1:0] STAGE_SEARCH = 3'd0;
	localparam logic [STAGE_W-1:0] STAGE_FIRST  = 3'd1;
	localparam logic [STAGE_W-1:0] STAGE_HIGH   = 3'd5;
	localparam logic [STAGE_W-1:0] STAGE_LOW    = 3'd6;

	// Fifth number must stay below 2^23, sixth below 2^31
	localparam int unsigned HIGH_W = 23;
	localparam int unsigned LOW_W  = 31;

	localparam int unsigned PORT_W  = 16;
	localparam int unsigned OUT_W   = 24;

	// Result word, lowest bit first: found, port_number, number_too_large
	typedef struct packed {
		logic [OUT_W-PORT_W-3:0] pad;
		logic                    number_too_large;
		logic [PORT_W-1:0]       port_number;
		logic                    found;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/pasv_reply_port_parser.sv
// pasv_reply_port_parser: scans a reply line for "(n,n,n,n,n,n)" and reports
// the port. Depends on pasv_pkg.
//
// Usage:
//   Slave channel (s_*): one character per word, s_tlast marks the line end.
//   Master channel (m_*): one result word per line, sent for the word that
//   carried s_tlast: found, port (low 16 bits of fifth*256+sixth) and an
//   overflow flag for a fifth number of 2^23 or more or a sixth of 2^31 or more.
//   Throughput: one character per cycle while no line end waits on a stalled result.
//   Path: a character is registered in the input register on accept and
//   scanned from there; the result word for the last character is written
//   from the scan logic into the result register.
//   The scan state updates from each registered character as it advances, so
//   consecutive lines follow each other with no gap.
//   Stall: the result register holds a word until m_tready; a further line
//   end then waits in the input register, and s_tready drops only while that
//   register holds a line end that cannot move on.
//   Reset: arst_n clears the scan state, both valid flags and the result.
//   After each result the scan state returns to its reset value.
`default_nettype none

module pasv_reply_port_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // [0] found, [16:1] port_number,
	                                    // [17] number_too_large, [23:18] zero
);

	localparam int unsigned SW = pasv_pkg::STAGE_W;
	localparam int unsigned HW = pasv_pkg::HIGH_W;
	localparam int unsigned LW = pasv_pkg::LOW_W;
	localparam int unsigned PW = pasv_pkg::PORT_W;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	// Scan state
	logic [SW-1:0] stage_q, stage_d;
	logic          digit_q, digit_d;
	logic [HW-1:0] high_q, high_d;
	logic          high_ovf_q, high_ovf_d;
	logic [LW-1:0] low_q, low_d;
	logic          low_ovf_q, low_ovf_d;
	logic          matched_q, matched_d;
	logic [PW-1:0] port_q, port_d;
	logic          err_q, err_d;

	// Result register
	logic              out_valid_q;
	pasv_pkg::result_t out_q;

	logic          is_digit, is_open;
	logic [3:0]    digit_val;
	logic [HW+3:0] high_mul;
	logic [LW+3:0] low_mul;
	logic          load_out;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign load_out = advance && last_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Character classes and decimal accumulate (x10 as shift-add)
	assign is_digit  = (byte_s1 >= pasv_pkg::CHR_ZERO) && (byte_s1 <= pasv_pkg::CHR_NINE);
	assign is_open   = (byte_s1 == pasv_pkg::CHR_OPEN);
	assign digit_val = byte_s1[3:0];
	assign high_mul  = {1'b0, high_q, 3'b000} + {3'b000, high_q, 1'b0}
	                 + {(HW)'(0), digit_val};
	assign low_mul   = {1'b0, low_q, 3'b000} + {3'b000, low_q, 1'b0}
	                 + {(LW)'(0), digit_val};

	// Next scan state for the registered character
	always_comb begin
		stage_d    = stage_q;
		digit_d    = digit_q;
		high_d     = high_q;
		high_ovf_d = high_ovf_q;
		low_d      = low_q;
		low_ovf_d  = low_ovf_q;
		matched_d  = matched_q;
		port_d     = port_q;
		err_d      = err_q;
		if (!matched_q) begin
			if (stage_q == pasv_pkg::STAGE_SEARCH || stage_q > pasv_pkg::STAGE_LOW) begin
				stage_d    = is_open ? pasv_pkg::STAGE_FIRST : pasv_pkg::STAGE_SEARCH;
				digit_d    = 1'b0;
				high_d     = '0;
				high_ovf_d = 1'b0;
				low_d      = '0;
				low_ovf_d  = 1'b0;
			end else if (is_digit) begin
				digit_d = 1'b1;
				if (stage_q == pasv_pkg::STAGE_HIGH) begin
					high_d     = high_mul[HW-1:0];
					high_ovf_d = high_ovf_q || (high_mul[HW+3:HW] != 4'd0);
				end else if (stage_q == pasv_pkg::STAGE_LOW) begin
					low_d     = low_mul[LW-1:0];
					low_ovf_d = low_ovf_q || (low_mul[LW+3:LW] != 4'd0);
				end
			end else if (byte_s1 == pasv_pkg::CHR_COMMA && digit_q
			             && stage_q < pasv_pkg::STAGE_LOW) begin
				stage_d = stage_q + SW'(1);
				digit_d = 1'b0;
			end else if (byte_s1 == pasv_pkg::CHR_CLOSE && digit_q
			             && stage_q == pasv_pkg::STAGE_LOW) begin
				// complete match: hold the port, restart search state
				matched_d  = 1'b1;
				err_d      = high_ovf_q || low_ovf_q;
				port_d     = (high_ovf_q || low_ovf_q) ? '0
				           : ({high_q[7:0], 8'h00} + low_q[PW-1:0]);
				stage_d    = pasv_pkg::STAGE_SEARCH;
				digit_d    = 1'b0;
				high_d     = '0;
				high_ovf_d = 1'b0;
				low_d      = '0;
				low_ovf_d  = 1'b0;
			end else begin
				stage_d    = is_open ? pasv_pkg::STAGE_FIRST : pasv_pkg::STAGE_SEARCH;
				digit_d    = 1'b0;
				high_d     = '0;
				high_ovf_d = 1'b0;
				low_d      = '0;
				low_ovf_d  = 1'b0;
			end
		end
	end

	// Scan state registers, cleared at line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q    <= pasv_pkg::STAGE_SEARCH;
			digit_q    <= 1'b0;
			high_q     <= '0;
			high_ovf_q <= 1'b0;
			low_q      <= '0;
			low_ovf_q  <= 1'b0;
			matched_q  <= 1'b0;
			port_q     <= '0;
			err_q      <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				stage_q    <= pasv_pkg::STAGE_SEARCH;
				digit_q    <= 1'b0;
				high_q     <= '0;
				high_ovf_q <= 1'b0;
				low_q      <= '0;
				low_ovf_q  <= 1'b0;
				matched_q  <= 1'b0;
				port_q     <= '0;
				err_q      <= 1'b0;
			end else begin
				stage_q    <= stage_d;
				digit_q    <= digit_d;
				high_q     <= high_d;
				high_ovf_q <= high_ovf_d;
				low_q      <= low_d;
				low_ovf_q  <= low_ovf_d;
				matched_q  <= matched_d;
				port_q     <= port_d;
				err_q      <= err_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (load_out) begin
			out_valid_q            <= 1'b1;
			out_q.pad              <= '0;
			out_q.found            <= matched_d;
			out_q.port_number      <= matched_d ? port_d : '0;
			out_q.number_too_large <= matched_d && err_d;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

`ifndef SYNTH
	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q <= pasv_pkg::STAGE_LOW)
		else $error("match stage out of range");

	a_digit_in_number: assert property (@(posedge clk) disable iff (!arst_n)
		digit_q |-> (stage_q != pasv_pkg::STAGE_SEARCH))
		else $error("digit flag set while searching");

	a_clear_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (stage_q == pasv_pkg::STAGE_SEARCH) && !matched_q && !digit_q)
		else $error("scan state not cleared after line end");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.found) |-> (out_q.port_number == '0)
		&& !out_q.number_too_large)
		else $error("result fields set without a match");

	a_error_zero_port: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.number_too_large) |-> (out_q.port_number == '0))
		else $error("port given with overflow flag");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> out_valid_q)
		else $error("result word dropped while stalled");
`endif

endmodule

`default_nettype wire
